>>> rtl/core/roi_approach_metrics_core_macros.svh
// Assertion macros shared by the ROI approach metrics core.
// Depends on nothing; included inside module bodies.
`ifndef ROI_APPROACH_METRICS_CORE_MACROS_SVH
`define ROI_APPROACH_METRICS_CORE_MACROS_SVH
// Implication checked every clock, muted during reset.
`define RAM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, muted during reset.
`define RAM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/ram_pkg.sv
// Package for the ROI approach metrics core: codes, constants, command types.
// Depends on nothing.
package ram_pkg;
  localparam int unsigned MaxPointsDefault = 1048576;
  localparam logic [16:0] DistNone = 17'h1FFFF;
  localparam logic [20:0] CntMax = 21'h1FFFFF;
  localparam logic [2:0] CfgLeft = 3'd0;
  localparam logic [2:0] CfgTop = 3'd1;
  localparam logic [2:0] CfgWidth = 3'd2;
  localparam logic [2:0] CfgHeight = 3'd3;
  localparam logic [2:0] CfgEnabled = 3'd4;
  localparam logic [2:0] CfgStart = 3'd5;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch_in;    // capture accepted word
    logic pair_start;  // evaluate rectangle, load sqrt operand
    logic sqrt_step;   // one root iteration
    logic pair_commit; // fold distance into sums
    logic div_start;   // load divider
    logic div_step;    // one quotient bit
    logic out_load;    // load result register
    logic traj_clear;  // clear trajectory state
    logic shift_prev;  // current point becomes previous
  } ram_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic pair_ok;  // pair qualifies for measurement
    logic is_last;
    logic need_div; // enabled and count nonzero
  } ram_sts_t;
endpackage

>>> rtl/core/roi_approach_metrics_core.sv
// Top level of the ROI approach metrics core.
// Depends on ram_pkg, ram_ctrl and ram_datapath.
//
//  channel | handshake            | payload
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | point_x, point_y, point_time, last_point
//  out     | out_valid/out_ready  | six metric fields
//
// A point that forms a measured pair runs 18 root steps before its distance is folded in.
// The last point adds the SumW-bit restoring divide if the ROI is enabled and a distance was measured.
// in_ready is low while a point is at work and while a result waits.
// Synchronous reset clears configuration and trajectory state.
module roi_approach_metrics_core #(
  parameter int unsigned MaxPoints = ram_pkg::MaxPointsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [31:0] point_time,
  input  logic last_point,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] time_in_target,
  output logic [20:0] entry_count,
  output logic reached,
  output logic signed [32:0] first_entry_latency,
  output logic [16:0] min_distance,
  output logic [16:0] mean_distance
);
  import ram_pkg::*;
  localparam int unsigned CntW = $clog2(MaxPoints) + 1;

  ram_cmd_t cmd;
  ram_sts_t sts;

  assign cfg_ready = 1'b1;

  ram_ctrl #(.CntW(CntW)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  ram_datapath #(.MaxPoints(MaxPoints), .CntW(CntW)) u_dp (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .point_x, .point_y, .point_time, .last_point, .cmd, .sts,
    .time_in_target, .entry_count, .reached, .first_entry_latency,
    .min_distance, .mean_distance
  );
endmodule

>>> rtl/core/ram_ctrl.sv
// Controller of the ROI approach metrics core: sequences sqrt and divide.
// Depends on ram_pkg and the macros header.
module ram_ctrl #(
  parameter int unsigned CntW = 21
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ram_pkg::ram_sts_t sts,
  output ram_pkg::ram_cmd_t cmd
);
  import ram_pkg::*;
  `include "roi_approach_metrics_core_macros.svh"

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEval = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StCommit = 3'd3;
  localparam logic [2:0] StFinal = 3'd4;
  localparam logic [2:0] StDiv = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;

  logic [2:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic out_valid_next;

  // Accept only when idle and no result waits.
  assign in_ready = (state == StIdle) && !out_valid;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      StIdle: begin
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1;
          state_next = StEval;
        end
      end
      StEval: begin
        if (sts.pair_ok) begin
          cmd.pair_start = 1'b1;
          cnt_next = 6'd0;
          state_next = StSqrt;
        end else begin
          state_next = StFinal;
        end
      end
      StSqrt: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd17) state_next = StCommit;
      end
      StCommit: begin
        cmd.pair_commit = 1'b1;
        state_next = StFinal;
      end
      StFinal: begin
        cmd.shift_prev = 1'b1;
        if (!sts.is_last) begin
          state_next = StIdle;
        end else if (sts.need_div) begin
          cmd.div_start = 1'b1;
          cnt_next = 6'd0;
          state_next = StDiv;
        end else begin
          state_next = StEmit;
        end
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(CntW + 16)) state_next = StEmit;
      end
      StEmit: begin
        cmd.out_load = 1'b1;
        cmd.traj_clear = 1'b1;
        out_valid_next = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  // Advance state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `RAM_ASSERT_IMP(a_ready_idle, in_ready, state == StIdle, "ready outside idle")
  `RAM_ASSERT_NXT(a_emit_valid, state == StEmit, out_valid, "emit without valid")
  `RAM_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule

>>> rtl/core/ram_datapath.sv
// Datapath of the ROI approach metrics core: registers, sqrt, divider.
// Depends on ram_pkg.
module ram_datapath #(
  parameter int unsigned MaxPoints = ram_pkg::MaxPointsDefault,
  parameter int unsigned CntW = 21
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [31:0] point_time,
  input  logic last_point,
  input  ram_pkg::ram_cmd_t cmd,
  output ram_pkg::ram_sts_t sts,
  output logic [31:0] time_in_target,
  output logic [20:0] entry_count,
  output logic reached,
  output logic signed [32:0] first_entry_latency,
  output logic [16:0] min_distance,
  output logic [16:0] mean_distance
);
  import ram_pkg::*;

  localparam int unsigned SumW = CntW + 17;
  localparam logic [CntW-1:0] CountLimit = CntW'(MaxPoints - 1);

  logic signed [15:0] roi_left, roi_top, roi_width, roi_height;
  logic roi_enabled;
  logic [31:0] trial_start;
  logic signed [15:0] cur_x, cur_y, prev_x, prev_y;
  logic [31:0] cur_time, prev_time;
  logic cur_last, have_prev, was_inside, reached_flag;
  logic [31:0] inside_time_acc;
  logic [20:0] entries_acc;
  logic signed [32:0] latency_reg;
  logic [SumW-1:0] distance_sum;
  logic [CntW-1:0] distance_count;
  logic [16:0] min_dist_reg;
  logic [35:0] sq_rem;
  logic [17:0] sq_root;
  logic [35:0] sq_val;
  logic [SumW-1:0] dv_num;
  logic [SumW:0] dv_rem;
  logic [SumW-1:0] dv_quo;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left <= '0; roi_top <= '0; roi_width <= '0; roi_height <= '0;
      roi_enabled <= 1'b0; trial_start <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgLeft: roi_left <= cfg_data[15:0];
        CfgTop: roi_top <= cfg_data[15:0];
        CfgWidth: roi_width <= cfg_data[15:0];
        CfgHeight: roi_height <= cfg_data[15:0];
        CfgEnabled: roi_enabled <= cfg_data[0];
        CfgStart: trial_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rectangle test and doubled centre offset of the previous point; time step and sum.
  logic signed [17:0] xb, yb, x1, x2, y1, y2, px, py;
  logic signed [18:0] ex, ey;
  logic in_roi;
  logic [31:0] dt;
  logic [32:0] tsum;
  always_comb begin
    xb = 18'(roi_left) + 18'(roi_width);
    yb = 18'(roi_top) + 18'(roi_height);
    px = 18'(prev_x);
    py = 18'(prev_y);
    x1 = (18'(roi_left) < xb) ? 18'(roi_left) : xb;
    x2 = (18'(roi_left) < xb) ? xb : 18'(roi_left);
    y1 = (18'(roi_top) < yb) ? 18'(roi_top) : yb;
    y2 = (18'(roi_top) < yb) ? yb : 18'(roi_top);
    in_roi = roi_enabled && px >= x1 && px <= x2 && py >= y1 && py <= y2;
    ex = 19'(px) * 19'sd2 - (19'(roi_left) * 19'sd2 + 19'(roi_width));
    ey = 19'(py) * 19'sd2 - (19'(roi_top) * 19'sd2 + 19'(roi_height));
    dt = cur_time - prev_time;
    tsum = {1'b0, inside_time_acc} + {1'b0, dt};
  end
  assign sts.pair_ok = have_prev && (cur_time > prev_time) && (distance_count < CountLimit);
  assign sts.is_last = cur_last;
  assign sts.need_div = roi_enabled && (distance_count != '0);

  // One root bit per step: test candidate against remainder.
  logic [37:0] trial;
  always_comb begin
    trial = {sq_rem[35:0], sq_val[35:34]} - {18'd0, sq_root, 2'b01};
  end

  // Restoring divide step.
  logic [SumW:0] dv_sh;
  always_comb dv_sh = {dv_rem[SumW-1:0], dv_num[SumW-1]};

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur_x <= point_x; cur_y <= point_y; cur_time <= point_time;
      cur_last <= last_point;
    end
    if (cmd.pair_start) begin
      sq_val <= 36'(ex * ex) + 36'(ey * ey);
      sq_rem <= '0;
      sq_root <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_val <= {sq_val[33:0], 2'b00};
      if (!trial[37]) begin
        sq_rem <= trial[35:0];
        sq_root <= {sq_root[16:0], 1'b1};
      end else begin
        sq_rem <= {sq_rem[33:0], sq_val[35:34]};
        sq_root <= {sq_root[16:0], 1'b0};
      end
    end
    if (cmd.div_start) begin
      dv_num <= distance_sum;
      dv_rem <= '0;
      dv_quo <= '0;
    end
    if (cmd.div_step) begin
      dv_num <= {dv_num[SumW-2:0], 1'b0};
      if (dv_sh >= {{(SumW+1-CntW){1'b0}}, distance_count}) begin
        dv_rem <= dv_sh - {{(SumW+1-CntW){1'b0}}, distance_count};
        dv_quo <= {dv_quo[SumW-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh;
        dv_quo <= {dv_quo[SumW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      if (!roi_enabled) begin
        time_in_target <= '0; entry_count <= '0; reached <= 1'b0;
        first_entry_latency <= '0; min_distance <= DistNone; mean_distance <= '0;
      end else begin
        time_in_target <= inside_time_acc;
        entry_count <= entries_acc;
        reached <= reached_flag;
        first_entry_latency <= latency_reg;
        if (distance_count == '0) begin
          min_distance <= DistNone; mean_distance <= '0;
        end else begin
          min_distance <= min_dist_reg;
          mean_distance <= (dv_quo > SumW'(DistNone)) ? DistNone : dv_quo[16:0];
        end
      end
    end
  end

  // Trajectory state.
  logic [16:0] pt_dist;
  assign pt_dist = sq_root[17:1];
  always_ff @(posedge clk) begin
    if (rst || cmd.traj_clear) begin
      prev_x <= '0; prev_y <= '0; prev_time <= '0;
      have_prev <= 1'b0; was_inside <= 1'b0; reached_flag <= 1'b0;
      inside_time_acc <= '0; entries_acc <= '0; latency_reg <= '0;
      distance_sum <= '0; distance_count <= '0; min_dist_reg <= DistNone;
    end else begin
      if (cmd.pair_start) begin
        if (in_roi) begin
          inside_time_acc <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
          if (!was_inside) begin
            if (entries_acc != CntMax) entries_acc <= entries_acc + 21'd1;
            if (!reached_flag) begin
              reached_flag <= 1'b1;
              latency_reg <= $signed({1'b0, prev_time}) - $signed({1'b0, trial_start});
            end
          end
        end
        was_inside <= in_roi;
      end
      if (cmd.pair_commit) begin
        distance_sum <= distance_sum + SumW'(pt_dist);
        distance_count <= distance_count + CntW'(1);
        if (pt_dist < min_dist_reg) min_dist_reg <= pt_dist;
      end
      if (cmd.shift_prev) begin
        prev_x <= cur_x; prev_y <= cur_y; prev_time <= cur_time; have_prev <= 1'b1;
      end
    end
  end
endmodule
